FILE: rtl/core/gram_matrix_accumulator_defines.svh
// Assertion macros for the sum-of-products matrix accumulator.
// Depends on nothing; included by the top level only.
`ifndef GRAM_MATRIX_ACCUMULATOR_DEFINES_SVH
`define GRAM_MATRIX_ACCUMULATOR_DEFINES_SVH

// Implication in the same cycle, checking suspended during reset.
`define GMA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the following cycle, checking suspended during reset.
`define GMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gma_pkg.sv
// Shared constants, command codes and helper functions of the matrix accumulator.
// Depends on nothing.
package gma_pkg;

  localparam int SIG_W   = 20;
  localparam int PROD_W  = 2 * SIG_W;
  localparam int SUM_W   = 64;
  localparam int VEC_LEN = 6;
  localparam int TRI_LEN = 21;
  localparam int IDX_W   = 3;
  localparam int TRI_W   = 5;

  // Constant element of the vector: 1.0 in Q12.8
  localparam logic signed [SIG_W-1:0] Q_ONE = SIG_W'(256);

  localparam logic CMD_ACC  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VEC_LEN - 1);

  // Start of each row in the packed upper triangle
  function automatic logic [TRI_W-1:0] row_base(input logic [IDX_W-1:0] r);
    logic [TRI_W-1:0] b;
    case (r)
      3'd0:    b = TRI_W'(0);
      3'd1:    b = TRI_W'(6);
      3'd2:    b = TRI_W'(11);
      3'd3:    b = TRI_W'(15);
      3'd4:    b = TRI_W'(18);
      3'd5:    b = TRI_W'(20);
      default: b = TRI_W'(0);
    endcase
    return b;
  endfunction

  // Packed index of entry (r,c), mirrored so the smaller index is the row
  function automatic logic [TRI_W-1:0] tri_index(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    lo = (r < c) ? r : c;
    hi = (r < c) ? c : r;
    return row_base(lo) + TRI_W'(hi - lo);
  endfunction

  // Saturating add of a product into a 64-bit sum
  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = {a[SUM_W-1], a} + (SUM_W+1)'(b);
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s[SUM_W-1:0];
  endfunction

endpackage

FILE: rtl/core/gram_matrix_accumulator.sv
// An accumulate word with hit set keeps busy high while its 21 products go through the one
// shared multiplier, one per cycle, and through the final write-back; one without hit or for
// an absent detector is dropped at once. A read word gives its strobe in the cycle after
// acceptance, busy high for that one cycle. No word is accepted while busy.
// Reset (rst, synchronous, active high) clears the sequencer and every entry's valid flag;
// an entry not yet written reads as zero, so no clearing pass is needed.
`include "gram_matrix_accumulator_defines.svh"

module gram_matrix_accumulator
  import gma_pkg::*;
#(
  parameter int NUM_DETECTORS = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command,
  input  logic                    detector,
  input  logic                    hit,
  input  logic signed [SIG_W-1:0] common_signal,
  input  logic signed [SIG_W-1:0] sector_1,
  input  logic signed [SIG_W-1:0] sector_2,
  input  logic signed [SIG_W-1:0] sector_3,
  input  logic signed [SIG_W-1:0] sector_4,
  input  logic [IDX_W-1:0]        read_row,
  input  logic [IDX_W-1:0]        read_col,
  output logic                    strobe,
  output logic signed [SUM_W-1:0] sum_value
);

  localparam int Depth = NUM_DETECTORS * TRI_LEN;
  localparam int AddrW = $clog2(Depth);

  // Sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ACC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]              state;
  logic [IDX_W-1:0]        i;
  logic [IDX_W-1:0]        j;
  logic [TRI_W-1:0]        k;
  logic [AddrW-1:0]        acc_addr;
  logic signed [SIG_W-1:0] vec [VEC_LEN-1];

  // Product stage, one word behind the address stage
  logic signed [PROD_W-1:0] prod;
  logic                     pipe_vld;
  logic [AddrW-1:0]         pipe_addr;

  // Matrix store and its read port
  logic [SUM_W-1:0] mem [Depth];
  logic [Depth-1:0] valid;
  logic [SUM_W-1:0] rd_data;
  logic             rd_vld;
  logic             rd_ok;

  logic                     accept;
  logic                     det_ok;
  logic                     idx_ok;
  logic [AddrW-1:0]         det_base;
  logic [AddrW-1:0]         port_addr;
  logic [AddrW-1:0]         rd_addr;
  logic signed [SIG_W-1:0]  op_a;
  logic signed [SIG_W-1:0]  op_b;
  logic signed [SUM_W-1:0]  old_sum;
  logic signed [SUM_W-1:0]  wr_data;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign det_ok = (int'(detector) < NUM_DETECTORS);
  assign idx_ok = (read_row <= IDX_LAST) && (read_col <= IDX_LAST);

  // Base of the selected detector's triangle; hold at zero for an absent one
  assign det_base  = (det_ok && detector) ? AddrW'(TRI_LEN) : '0;
  assign port_addr = det_base + AddrW'(tri_index(read_row, read_col));

  // Address the store from the ports when idle, from the walk otherwise
  assign rd_addr = (state == S_IDLE) ? port_addr : acc_addr;

  // Operand select for the shared multiplier; index 5 is the constant one
  assign op_a = (i == IDX_LAST) ? Q_ONE : vec[i];
  assign op_b = (j == IDX_LAST) ? Q_ONE : vec[j];

  // Write-back: an entry never written counts as zero
  assign old_sum = rd_vld ? rd_data : '0;
  assign wr_data = sat_add(old_sum, prod);

  // Sequencer: walk the 21 upper-triangle entries row by row
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            i <= '0;
            j <= '0;
            k <= '0;
            if (command == CMD_READ) begin
              state <= S_READ;
            end else if (hit && det_ok) begin
              state <= S_ACC;
            end
          end
        end
        S_ACC: begin
          k <= k + TRI_W'(1);
          if (j == IDX_LAST) begin
            i <= i + IDX_W'(1);
            j <= i + IDX_W'(1);
          end else begin
            j <= j + IDX_W'(1);
          end
          if (k == TRI_W'(TRI_LEN - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_IDLE;
        S_READ:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the event vector and the walk's start address
  always_ff @(posedge clk) begin
    if (accept) begin
      vec[0]   <= common_signal;
      vec[1]   <= sector_1;
      vec[2]   <= sector_2;
      vec[3]   <= sector_3;
      vec[4]   <= sector_4;
      acc_addr <= det_base;
    end else if (state == S_ACC) begin
      acc_addr <= acc_addr + AddrW'(1);
    end
  end

  // One product per cycle; the address travels with it to the write-back
  always_ff @(posedge clk) begin
    prod      <= PROD_W'(op_a) * PROD_W'(op_b);
    pipe_addr <= acc_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld <= 1'b0;
      valid    <= '0;
      rd_vld   <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      pipe_vld <= (state == S_ACC);
      rd_vld   <= valid[rd_addr];
      if (accept) begin
        rd_ok <= det_ok && idx_ok;
      end
      if (pipe_vld) begin
        valid[pipe_addr] <= 1'b1;
      end
    end
  end

  // Store: one write port for the write-back, one registered read port
  always_ff @(posedge clk) begin
    if (pipe_vld) begin
      mem[pipe_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Present a read result for exactly one cycle; zero for a bad index or detector
  assign strobe    = (state == S_READ);
  assign sum_value = (rd_ok && rd_vld) ? rd_data : '0;

  `GMA_ASSERT_NEXT(a_read_gives_strobe, clk, rst, accept && (command == CMD_READ), strobe, "read word did not produce a strobe")
  `GMA_ASSERT_NEXT(a_strobe_single, clk, rst, strobe, !strobe && !busy, "strobe held beyond one cycle")
  `GMA_ASSERT_NOW(a_walk_in_range, clk, rst, state == S_ACC, k < TRI_W'(TRI_LEN), "triangle walk ran past its end")
  `GMA_ASSERT_NOW(a_writeback_follows_walk, clk, rst, pipe_vld, $past(state == S_ACC), "write-back without a preceding product")

endmodule
